>>> rtl/comment_strip_space_collapse_unit_macros.svh
`ifndef COMMENT_STRIP_SPACE_COLLAPSE_UNIT_MACROS_SVH
`define COMMENT_STRIP_SPACE_COLLAPSE_UNIT_MACROS_SVH

// cond must never hold at a clock edge outside reset
`define CSSC_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("cssc: forbidden condition seen");

// whenever a holds, b holds at the same edge
`define CSSC_ASSERT_IMPLIES(lbl, a, b) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |-> (b)) \
    else $error("cssc: implication violated");

`endif

>>> rtl/cssc_pkg.sv
`default_nettype none

package cssc_pkg;

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_VT    = 8'h0B;

  // output queue depth: one beat waiting plus two from a new byte
  localparam int unsigned QDepth = 3;
  localparam int unsigned QIdxW  = $clog2(QDepth);

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_LINE   = 2'd1,
    MODE_BLOCK  = 2'd2
  } mode_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_run_last;
  } out_beat_t;

  // beats caused by one input byte, item[0] goes out first
  typedef struct packed {
    logic [1:0]      cnt;
    out_beat_t [1:0] item;
  } res_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
           (c == CH_CR) || (c == CH_FF) || (c == CH_VT);
  endfunction

endpackage

`default_nettype wire

>>> rtl/cssc_core.sv
`default_nettype none
`include "comment_strip_space_collapse_unit_macros.svh"

module cssc_core import cssc_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     fire_i,
  input  wire in_beat_t beat_i,
  output res_t          res_o
);

  mode_e mode_q, mode_d;
  logic  slash_q, slash_d;
  logic  star_q, star_d;
  logic  prev_space_q, prev_space_d;

  // emit requests: held slash ahead of byte, the byte, slash flushed at end
  logic       req_pre, req_byte, req_post;
  logic [7:0] c;

  assign c = beat_i.in_byte;

  // next state and emit requests
  always_comb begin
    logic handled;
    handled  = 1'b0;
    mode_d   = mode_q;
    slash_d  = slash_q;
    star_d   = star_q;
    req_pre  = 1'b0;
    req_byte = 1'b0;
    req_post = 1'b0;
    unique case (mode_q)
      MODE_LINE: begin
        if (c == CH_LF) begin
          mode_d   = MODE_NORMAL;
          req_byte = 1'b1;
        end
      end
      MODE_BLOCK: begin
        if (star_q && (c == CH_SLASH)) begin
          mode_d = MODE_NORMAL;
          star_d = 1'b0;
        end else begin
          star_d = (c == CH_STAR);
        end
      end
      default: begin
        // unused mode code behaves as normal text
        if (slash_q) begin
          slash_d = 1'b0;
          if (c == CH_SLASH) begin
            mode_d  = MODE_LINE;
            handled = 1'b1;
          end else if (c == CH_STAR) begin
            mode_d  = MODE_BLOCK;
            star_d  = 1'b0;
            handled = 1'b1;
          end else begin
            req_pre = 1'b1;
          end
        end
        if (!handled) begin
          if (c == CH_SLASH) begin
            slash_d = 1'b1;
          end else begin
            req_byte = 1'b1;
          end
        end
      end
    endcase
    if (beat_i.in_last) begin
      req_post = slash_d;
      mode_d   = MODE_NORMAL;
      slash_d  = 1'b0;
      star_d   = 1'b0;
    end
  end

  // whitespace collapse over the requested bytes
  always_comb begin
    logic [2:0]       req;
    logic [2:0][7:0]  ch;
    logic             ps;
    logic [1:0]       n;
    req   = {req_post, req_byte, req_pre};
    ch    = {CH_SLASH, c, CH_SLASH};
    ps    = prev_space_q;
    n     = 2'd0;
    res_o = '0;
    for (int k = 0; k < 3; k++) begin
      if (req[k]) begin
        if (is_blank(ch[k])) begin
          if (!ps) begin
            ps = 1'b1;
            res_o.item[n[0]] = '{out_byte: CH_SPACE, out_run_last: 1'b0};
            n = n + 2'd1;
          end
        end else begin
          ps = 1'b0;
          res_o.item[n[0]] = '{out_byte: ch[k], out_run_last: 1'b0};
          n = n + 2'd1;
        end
      end
    end
    if (n == 2'd2) begin
      res_o.item[1].out_run_last = 1'b1;
    end else if (n == 2'd1) begin
      res_o.item[0].out_run_last = 1'b1;
    end
    res_o.cnt    = n;
    prev_space_d = beat_i.in_last ? 1'b0 : ps;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_NORMAL;
      slash_q      <= 1'b0;
      star_q       <= 1'b0;
      prev_space_q <= 1'b0;
    end else if (fire_i) begin
      mode_q       <= mode_d;
      slash_q      <= slash_d;
      star_q       <= star_d;
      prev_space_q <= prev_space_d;
    end
  end

  `CSSC_ASSERT_IMPLIES(a_slash_only_normal, slash_q, mode_q == MODE_NORMAL)
  `CSSC_ASSERT_IMPLIES(a_star_only_block, star_q, mode_q == MODE_BLOCK)
  `CSSC_ASSERT_IMPLIES(a_pair_starts_slash, res_o.cnt == 2'd2,
    (res_o.item[0].out_byte == CH_SLASH) && !res_o.item[0].out_run_last)

endmodule

`default_nettype wire

>>> rtl/cssc_outq.sv
`default_nettype none
`include "comment_strip_space_collapse_unit_macros.svh"

module cssc_outq import cssc_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire res_t      push_i,
  output logic           space_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_beat_t      out_data_o
);

  out_beat_t [QDepth-1:0] ent_q, ent_d;
  logic [QIdxW-1:0]       cnt_q, cnt_d;
  logic                   pop;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = ent_q[0];
  // room for the two beats a byte may cause
  assign space_o     = (cnt_q <= QIdxW'(QDepth - 2));

  always_comb begin
    logic [QIdxW-1:0] base;
    ent_d = ent_q;
    base  = cnt_q;
    if (pop) begin
      for (int k = 0; k < QDepth - 1; k++) begin
        ent_d[k] = ent_q[k+1];
      end
      base = base - QIdxW'(1);
    end
    if (push_i.cnt != 2'd0) begin
      ent_d[base] = push_i.item[0];
    end
    if (push_i.cnt == 2'd2) begin
      ent_d[QIdxW'(base + QIdxW'(1))] = push_i.item[1];
    end
    cnt_d = QIdxW'(base + QIdxW'(push_i.cnt));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  `CSSC_ASSERT_NEVER(a_cnt_range, cnt_q > QIdxW'(QDepth))
  `CSSC_ASSERT_IMPLIES(a_push_has_room, push_i.cnt != 2'd0, space_o)

endmodule

`default_nettype wire

>>> rtl/comment_strip_space_collapse_unit.sv
// channel | direction | handshake              | payload
// in      | input     | in_valid_i / in_ready_o   | in_data_i  (in_beat_t)
// out     | output    | out_valid_o / out_ready_i | out_data_o (out_beat_t)
//
// one byte per cycle; a byte that releases a held slash together with itself
// causes two beats and keeps in_ready_o low while the single
// output port drains the 3-entry output queue
// first beat of a byte is registered in the output queue, not passed through
// reset clears the comment state and empties the queue, no clearing pass
// out_ready_i low fills the queue; in_ready_o drops with two beats waiting
`default_nettype none

module comment_strip_space_collapse_unit import cssc_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_beat_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_beat_t      out_data_o
);

  logic fire;
  logic space;
  res_t res;
  res_t push;

  assign in_ready_o = space;
  assign fire       = in_valid_i && in_ready_o;
  assign push       = fire ? res : '0;

  cssc_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .beat_i (in_data_i),
    .res_o  (res)
  );

  cssc_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
